FILE: design/tilt_compensated_attitude_macros.svh
// Assertion macros shared by the tilt-compensated attitude RTL.
// Included by the modules that carry assertions; no other dependencies.
`ifndef TILT_COMPENSATED_ATTITUDE_MACROS_SVH
`define TILT_COMPENSATED_ATTITUDE_MACROS_SVH
`ifndef SYNTH
`define TCA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tca assertion failed");
`define TCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tca assertion failed");
`else
`define TCA_ASSERT(lbl, clk, rstn, prop)
`define TCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/tca_pkg.sv
// Types, constants and the arctangent table of the tilt-compensated attitude block.
// No dependencies.
package tca_pkg;

  localparam int unsigned SampleW        = 16;
  localparam int unsigned AngleW         = 16;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned QueueDepth     = 2;
  // square root operands: 32-bit sum of squares scaled by 2^16
  localparam int unsigned SqrtInW        = 48;
  localparam int unsigned SqrtOutW       = SqrtInW / 2;
  // CORDIC x/y datapath and angle accumulator (pi/2^31 per unit)
  localparam int unsigned CordicDW       = 62;
  localparam int unsigned AngW           = 35;
  localparam int unsigned AtanIdxW       = 6;
  localparam int unsigned RoundShift     = 32 - AngleW;
  localparam logic signed [AngW-1:0] AngPi = AngW'(64'd2147483648);

  typedef struct packed {
    logic signed [SampleW-1:0] acc_x;
    logic signed [SampleW-1:0] acc_y;
    logic signed [SampleW-1:0] acc_z;
    logic signed [SampleW-1:0] mag_x;
    logic signed [SampleW-1:0] mag_y;
    logic signed [SampleW-1:0] mag_z;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               zero_gravity;
  } result_t;

  typedef struct packed {
    logic    zero_g;
    sample_t smp;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL1,
    BK_SUM,
    BK_MUL2,
    BK_SQRT_START,
    BK_SQRT_WAIT,
    BK_NUM,
    BK_CORD_START,
    BK_CORD_WAIT,
    BK_DONE
  } back_state_e;

  // atan(2^-i) in pi/2^31 units, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_entry(input logic [AtanIdxW-1:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'd536870912;
      6'd1:  v = 32'd316933406;
      6'd2:  v = 32'd167458907;
      6'd3:  v = 32'd85004756;
      6'd4:  v = 32'd42667331;
      6'd5:  v = 32'd21354465;
      6'd6:  v = 32'd10680862;
      6'd7:  v = 32'd5340245;
      6'd8:  v = 32'd2670163;
      6'd9:  v = 32'd1335087;
      6'd10: v = 32'd667544;
      6'd11: v = 32'd333772;
      6'd12: v = 32'd166886;
      6'd13: v = 32'd83443;
      6'd14: v = 32'd41722;
      6'd15: v = 32'd20861;
      6'd16: v = 32'd10430;
      6'd17: v = 32'd5215;
      6'd18: v = 32'd2608;
      6'd19: v = 32'd1304;
      6'd20: v = 32'd652;
      6'd21: v = 32'd326;
      6'd22: v = 32'd163;
      6'd23: v = 32'd81;
      6'd24: v = 32'd41;
      6'd25: v = 32'd20;
      6'd26: v = 32'd10;
      6'd27: v = 32'd5;
      6'd28: v = 32'd3;
      6'd29: v = 32'd1;
      6'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return $signed(AngW'(v));
  endfunction

endpackage

FILE: design/tca_isqrt.sv
// Iterative integer square root, one result bit per cycle (floor).
// Depends on nothing but its parameter.
module tca_isqrt #(
  parameter int unsigned InW = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [InW-1:0]       rad_i,
  output logic                 done_o,
  output logic [InW/2-1:0]     root_o
);
  localparam int unsigned OutW = InW / 2;
  localparam int unsigned CntW = $clog2(OutW);

  logic [InW-1:0]  rad_q;
  logic [OutW+1:0] rem_q, rem_sh, trial;
  logic [OutW-1:0] root_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q, ge;

  assign rem_sh = {rem_q[OutW-1:0], rad_q[InW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(OutW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[OutW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: design/tca_cordic.sv
// Vectoring CORDIC arctangent, one micro-rotation per cycle.
// Depends on tca_pkg for the angle table and angle width.
module tca_cordic #(
  parameter int unsigned DataW = 62,
  parameter int unsigned Steps = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [DataW-1:0]          x_i,
  input  logic signed [DataW-1:0]          y_i,
  output logic                             done_o,
  output logic signed [tca_pkg::AngW-1:0]  z_o
);
  localparam int unsigned IterW = $clog2(Steps + 1);

  logic signed [DataW-1:0]         x_q, y_q, xs, ys;
  logic signed [tca_pkg::AngW-1:0] z_q, step_ang;
  logic [IterW-1:0]                iter_q;
  logic                            busy_q, done_q, zero_q;

  assign xs       = x_q >>> iter_q;
  assign ys       = y_q >>> iter_q;
  assign step_ang = tca_pkg::atan_entry(tca_pkg::AtanIdxW'(iter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == IterW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // left half plane: rotate by pi first
      if (x_i < 0) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= (y_i >= 0) ? tca_pkg::AngPi : -tca_pkg::AngPi;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + step_ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - step_ang;
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = zero_q ? '0 : z_q;

endmodule

FILE: design/tca_front.sv
// Input stage: registers a sample transaction and flags zero acceleration.
// Depends on tca_pkg.
module tca_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tca_pkg::sample_t in_i,
  output logic             push_o,
  input  logic             full_i,
  output tca_pkg::item_t   item_o
);
  logic           v_q, v_d, accept;
  tca_pkg::item_t item_q;

  assign push_o     = v_q && !full_i;
  assign in_ready_o = !v_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    v_d = v_q;
    if (accept)      v_d = 1'b1;
    else if (push_o) v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= v_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.zero_g <= (in_i.acc_x == '0) && (in_i.acc_y == '0) && (in_i.acc_z == '0);
      item_q.smp    <= in_i;
    end
  end

  assign item_o = item_q;

endmodule

FILE: design/tca_fifo.sv
// Short queue of classified samples between the front and the back end.
// Depends on tca_pkg and the assertion macro header.
`include "tilt_compensated_attitude_macros.svh"
module tca_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tca_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tca_pkg::item_t data_o,
  output logic           empty_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tca_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `TCA_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)
  `TCA_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)

endmodule

FILE: design/tca_back.sv
// Back end: products, square roots and three CORDIC arctangents per sample,
// ending in the output register. Depends on tca_pkg, tca_isqrt, tca_cordic.
`include "tilt_compensated_attitude_macros.svh"
module tca_back #(
  parameter int unsigned CordicSteps = tca_pkg::CordicStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  tca_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tca_pkg::result_t out_o
);
  localparam int unsigned DW = tca_pkg::CordicDW;
  localparam int unsigned ZW = tca_pkg::AngW;

  tca_pkg::back_state_e state_q, state_d;
  tca_pkg::item_t       smp_q;
  tca_pkg::result_t     out_q;
  logic                 out_valid_q, out_load, sqrt_start, cord_start;

  logic signed [31:0] p_xx_q, p_yy_q, p_zz_q, p_myaz_q, p_mzay_q, p_myay_q, p_mzaz_q;
  logic [31:0]        ryz2_q, g2_q;
  logic signed [32:0] cross_q, dot_q;
  logic signed [48:0] t1_q, t2_q;
  logic signed [49:0] den_diff;
  logic signed [57:0] num_prod;
  logic signed [DW-1:0] num_q, den_q;

  logic                          ryz_done, g_done, hd_done, pt_done, rl_done;
  logic [tca_pkg::SqrtOutW-1:0]  ryz_root, g_root;
  logic signed [ZW-1:0]          hd_z, pt_z, rl_z;

  // round half up to the output angle width, optional clamp to +-half pi
  function automatic logic signed [15:0] angle_round(input logic signed [ZW-1:0] z,
                                                     input logic clamp);
    logic signed [ZW-1:0] zr, r, q;
    q  = ZW'(1) <<< (tca_pkg::AngleW - 2);
    zr = z + (ZW'(1) <<< (tca_pkg::RoundShift - 1));
    r  = zr >>> tca_pkg::RoundShift;
    if (clamp && (r > q))  r = q;
    if (clamp && (r < -q)) r = -q;
    return r[15:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tca_pkg::BK_IDLE:       if (!empty_i) state_d = tca_pkg::BK_MUL1;
      tca_pkg::BK_MUL1:       state_d = tca_pkg::BK_SUM;
      tca_pkg::BK_SUM:        state_d = tca_pkg::BK_MUL2;
      tca_pkg::BK_MUL2:       state_d = tca_pkg::BK_SQRT_START;
      tca_pkg::BK_SQRT_START: state_d = tca_pkg::BK_SQRT_WAIT;
      tca_pkg::BK_SQRT_WAIT:  if (g_done) state_d = tca_pkg::BK_NUM;
      tca_pkg::BK_NUM:        state_d = tca_pkg::BK_CORD_START;
      tca_pkg::BK_CORD_START: state_d = tca_pkg::BK_CORD_WAIT;
      tca_pkg::BK_CORD_WAIT:  if (hd_done) state_d = tca_pkg::BK_DONE;
      tca_pkg::BK_DONE:       if (!out_valid_q || out_ready_i) state_d = tca_pkg::BK_IDLE;
      default:                state_d = tca_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o      = 1'b0;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tca_pkg::BK_IDLE:       pop_o      = !empty_i;
      tca_pkg::BK_SQRT_START: sqrt_start = 1'b1;
      tca_pkg::BK_CORD_START: cord_start = 1'b1;
      tca_pkg::BK_DONE:       out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tca_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign den_diff = t1_q - t2_q;
  assign num_prod = cross_q * $signed({1'b0, g_root});

  always_ff @(posedge clk_i) begin
    case (state_q)
      tca_pkg::BK_IDLE: if (pop_o) smp_q <= item_i;
      tca_pkg::BK_MUL1: begin
        p_xx_q   <= smp_q.smp.acc_x * smp_q.smp.acc_x;
        p_yy_q   <= smp_q.smp.acc_y * smp_q.smp.acc_y;
        p_zz_q   <= smp_q.smp.acc_z * smp_q.smp.acc_z;
        p_myaz_q <= smp_q.smp.mag_y * smp_q.smp.acc_z;
        p_mzay_q <= smp_q.smp.mag_z * smp_q.smp.acc_y;
        p_myay_q <= smp_q.smp.mag_y * smp_q.smp.acc_y;
        p_mzaz_q <= smp_q.smp.mag_z * smp_q.smp.acc_z;
      end
      tca_pkg::BK_SUM: begin
        ryz2_q  <= $unsigned(p_yy_q) + $unsigned(p_zz_q);
        g2_q    <= $unsigned(p_xx_q) + $unsigned(p_yy_q) + $unsigned(p_zz_q);
        cross_q <= p_myaz_q - p_mzay_q;
        dot_q   <= p_myay_q + p_mzaz_q;
      end
      tca_pkg::BK_MUL2: begin
        t1_q <= smp_q.smp.mag_x * $signed({1'b0, ryz2_q});
        t2_q <= smp_q.smp.acc_x * dot_q;
      end
      tca_pkg::BK_SQRT_START: den_q <= DW'(den_diff) <<< 8;
      tca_pkg::BK_NUM:        num_q <= DW'(num_prod);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.zero_gravity <= smp_q.zero_g;
      out_q.heading      <= smp_q.zero_g ? '0 : angle_round(hd_z, 1'b0);
      out_q.pitch        <= smp_q.zero_g ? '0 : angle_round(pt_z, 1'b1);
      out_q.roll         <= smp_q.zero_g ? '0 : angle_round(rl_z, 1'b0);
    end
  end

  tca_isqrt #(.InW(tca_pkg::SqrtInW)) u_sqrt_ryz (
    .clk_i, .rst_ni, .start_i(sqrt_start),
    .rad_i({ryz2_q, 16'b0}), .done_o(ryz_done), .root_o(ryz_root)
  );

  tca_isqrt #(.InW(tca_pkg::SqrtInW)) u_sqrt_g (
    .clk_i, .rst_ni, .start_i(sqrt_start),
    .rad_i({g2_q, 16'b0}), .done_o(g_done), .root_o(g_root)
  );

  tca_cordic #(.DataW(DW), .Steps(CordicSteps)) u_cordic_hd (
    .clk_i, .rst_ni, .start_i(cord_start),
    .x_i(den_q), .y_i(num_q), .done_o(hd_done), .z_o(hd_z)
  );

  tca_cordic #(.DataW(DW), .Steps(CordicSteps)) u_cordic_pt (
    .clk_i, .rst_ni, .start_i(cord_start),
    .x_i($signed({{(DW - tca_pkg::SqrtOutW){1'b0}}, ryz_root})),
    .y_i(DW'(smp_q.smp.acc_x) <<< 8), .done_o(pt_done), .z_o(pt_z)
  );

  tca_cordic #(.DataW(DW), .Steps(CordicSteps)) u_cordic_rl (
    .clk_i, .rst_ni, .start_i(cord_start),
    .x_i(-DW'(smp_q.smp.acc_z)), .y_i(-DW'(smp_q.smp.acc_y)),
    .done_o(rl_done), .z_o(rl_z)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // all units of a kind run the same number of steps
  `TCA_ASSERT(a_sqrt_lockstep, clk_i, rst_ni, ryz_done == g_done)
  `TCA_ASSERT(a_cordic_lockstep, clk_i, rst_ni, (hd_done == pt_done) && (hd_done == rl_done))
  `TCA_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load, out_valid_o)

endmodule

FILE: design/tilt_compensated_attitude.sv
// Tilt-compensated compass attitude: pitch, roll and heading from one
// accelerometer and magnetometer sample. Top level; depends on tca_pkg,
// tca_front, tca_fifo, tca_back.
//
// One sample transaction in, one result transaction out, in order. The back
// end works on one sample at a time: a queue pop, products, sums and
// products again, a 24-bit square root (one root bit per cycle) with a
// state to start it and one to see it finish, a state for the heading
// numerator, a CORDIC start state, CORDIC_STEPS micro-rotations of three
// arctangent units running side by side plus a state to see them finish,
// then the output register. That back-end loop sets the sustained
// rate. Inputs are taken into a register and a two-entry queue while the
// back end is busy, so up to three samples can wait upstream of the back
// end. Angles are in pi/32768 units; a zero acceleration vector gives
// zero_gravity = 1 and zero angles.
`include "tilt_compensated_attitude_macros.svh"
module tilt_compensated_attitude #(
  parameter int unsigned CORDIC_STEPS = tca_pkg::CordicStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tca_pkg::sample_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tca_pkg::result_t out_o
);
  logic           push, full, pop, empty;
  tca_pkg::item_t front_item, queue_item;

  tca_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .push_o(push), .full_i(full), .item_o(front_item)
  );

  tca_fifo #(.Depth(tca_pkg::QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(front_item), .full_o(full),
    .pop_i(pop), .data_o(queue_item), .empty_o(empty)
  );

  tca_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(queue_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_o
  );

  `TCA_ASSERT(a_zero_g_angles, clk_i, rst_ni, (out_valid_o && out_o.zero_gravity) |-> ((out_o.heading == 16'sd0) && (out_o.pitch == 16'sd0) && (out_o.roll == 16'sd0)))
  `TCA_ASSERT(a_pitch_range, clk_i, rst_ni, out_valid_o |-> ((out_o.pitch <= 16'sd16384) && (out_o.pitch >= -16'sd16384)))

endmodule
